FILE: sv/tpd_pkg.sv
package tpd_pkg;

    // input packet field layout
    localparam int unsigned PROX_BIT        = 6;
    localparam int unsigned BTN_FLAG_BIT    = 3;
    localparam int unsigned BANK0_BIT       = 3;
    localparam int unsigned BANK1_BIT       = 4;
    localparam int unsigned BANK2_BIT       = 5;
    localparam int unsigned COORD_HIGH_W    = 2;
    localparam int unsigned COORD_W         = 16;

    // macro bank offsets
    localparam logic [8:0] MACRO_BANK1_OFFSET = 9'd12;
    localparam logic [8:0] MACRO_BANK2_OFFSET = 9'd24;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IS_MACRO_PAD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ABSOLUTE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_X        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_Y        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_COLS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_ROWS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_DIVISOR = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_MAX_X        = 16'd5103;
    localparam logic [15:0] RST_MAX_Y        = 16'd3711;
    localparam logic [9:0]  RST_SCREEN_COLS  = 10'd80;
    localparam logic [9:0]  RST_SCREEN_ROWS  = 10'd25;
    localparam logic [7:0]  RST_JUMP_DIVISOR = 8'd20;

    // report kinds
    localparam logic [2:0] KIND_CLEARED   = 3'd0;
    localparam logic [2:0] KIND_MACRO     = 3'd1;
    localparam logic [2:0] KIND_NO_CHANGE = 3'd2;
    localparam logic [2:0] KIND_ABSOLUTE  = 3'd3;
    localparam logic [2:0] KIND_RELATIVE  = 3'd4;

    // shared divider geometry
    localparam int unsigned DIV_DIVIDEND_W      = 26;
    localparam int unsigned DIV_DIVISOR_W       = 18;
    localparam int unsigned DIV_SHORT_W         = 18;
    localparam int unsigned DIV_STEPS_PER_CYCLE = 2;
    localparam int unsigned DIV_SHORT_SHIFT     = DIV_DIVIDEND_W - DIV_SHORT_W;
    localparam int unsigned DIV_LONG_CYCLES     = DIV_DIVIDEND_W / DIV_STEPS_PER_CYCLE;
    localparam int unsigned DIV_SHORT_CYCLES    = DIV_SHORT_W / DIV_STEPS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W           = $clog2(DIV_LONG_CYCLES + 1);

    // divider request from the sequencer
    typedef struct packed {
        logic start;
        logic long_op;
    } t_div_req;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_THX,
        ST_THY,
        ST_QX,
        ST_QY,
        ST_DX,
        ST_DY,
        ST_SX,
        ST_SY,
        ST_FIN
    } t_state;

endpackage

FILE: sv/tpd_in_if.sv
interface tpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [6:0] byte1;
    logic [6:0] byte2;
    logic [7:0] byte3;
    logic [6:0] byte4;
    logic [6:0] byte5;
    logic [7:0] byte6;

    modport source (
        output valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        input  ready
    );

    modport sink (
        input  valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
        output ready
    );
endinterface

FILE: sv/tpd_out_if.sv
interface tpd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         report_kind;
    logic [9:0]         screen_x;
    logic [9:0]         screen_y;
    logic signed [17:0] delta_x;
    logic signed [17:0] delta_y;
    logic [2:0]         buttons;
    logic [8:0]         macro_code;

    modport source (
        output valid, report_kind, screen_x, screen_y, delta_x, delta_y, buttons,
               macro_code,
        input  ready
    );

    modport sink (
        input  valid, report_kind, screen_x, screen_y, delta_x, delta_y, buttons,
               macro_code,
        output ready
    );
endinterface

FILE: sv/tablet_packet_decoder_unit.sv
// one packet in, one report out; ready is low from acceptance until the report is registered
// out of proximity: no division before the report; absolute mode: two long divisions
// relative mode: two short divisions on a jump, six short divisions otherwise
// all divisions go to one shared divider, 2 quotient bits a cycle
// a new packet is taken the cycle after the report is registered, even while it waits
// synchronous active-low reset: registers to defaults, previous point to none, no report
module tablet_packet_decoder_unit
    import tpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    tpd_in_if.sink                 i_in,
    tpd_out_if.source              o_out
);

    // configuration registers
    logic        r_cfg_macro_pad;
    logic        r_cfg_absolute;
    logic [15:0] r_cfg_max_x;
    logic [15:0] r_cfg_max_y;
    logic [9:0]  r_cfg_cols;
    logic [9:0]  r_cfg_rows;
    logic [7:0]  r_cfg_jump_div;

    // sequencer and previous point
    t_state             r_state;
    t_state             n_state;
    logic signed [16:0] r_prev_x;
    logic [15:0]        r_prev_y;

    // working values of the packet in flight
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic [16:0] r_adx;
    logic [16:0] r_ady;
    logic        r_sdx;
    logic        r_sdy;
    logic [15:0] r_thx;
    logic [15:0] r_qx;
    logic [15:0] r_qy;

    // staged report
    logic [2:0]         r_kind;
    logic [9:0]         r_sx;
    logic [9:0]         r_sy;
    logic signed [17:0] r_dx;
    logic signed [17:0] r_dy;
    logic [2:0]         r_btn;
    logic [8:0]         r_mac;

    // output register
    logic               r_out_valid;
    logic [2:0]         r_o_kind;
    logic [9:0]         r_o_sx;
    logic [9:0]         r_o_sy;
    logic signed [17:0] r_o_dx;
    logic signed [17:0] r_o_dy;
    logic [2:0]         r_o_btn;
    logic [8:0]         r_o_mac;

    // combinational
    logic                      w_in_ready;
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_fin_load;
    logic                      w_jump;
    t_div_req                  w_div_req;
    logic [DIV_DIVIDEND_W-1:0] w_div_dividend;
    logic [DIV_DIVISOR_W-1:0]  w_div_divisor;
    logic                      w_div_done;
    logic [DIV_DIVIDEND_W-1:0] w_div_quo;
    logic [15:0]               w_mx_nz;
    logic [15:0]               w_my_nz;
    logic [9:0]                w_cols_nz;
    logic [9:0]                w_rows_nz;
    logic [7:0]                w_dv_nz;
    logic [DIV_DIVISOR_W-1:0]  w_step_div_x;
    logic [DIV_DIVISOR_W-1:0]  w_step_div_y;
    logic [DIV_DIVIDEND_W-1:0] w_prod_x;
    logic [DIV_DIVIDEND_W-1:0] w_prod_y;
    logic [15:0]               w_x_raw;
    logic [15:0]               w_y_raw;
    logic [15:0]               w_x_clamp;
    logic [15:0]               w_y_clamp;
    logic signed [17:0]        w_diff_x;
    logic signed [17:0]        w_diff_y;
    logic [8:0]                w_macro;
    logic [16:0]               w_q17;

    // zero registers act as one wherever they divide
    assign w_mx_nz   = (r_cfg_max_x == '0) ? 16'd1 : r_cfg_max_x;
    assign w_my_nz   = (r_cfg_max_y == '0) ? 16'd1 : r_cfg_max_y;
    assign w_cols_nz = (r_cfg_cols == '0) ? 10'd1 : r_cfg_cols;
    assign w_rows_nz = (r_cfg_rows == '0) ? 10'd1 : r_cfg_rows;
    assign w_dv_nz   = (r_cfg_jump_div == '0) ? 8'd1 : r_cfg_jump_div;

    // motion step divisor: max / cells / divisor taken as one division
    assign w_step_div_x = DIV_DIVISOR_W'(w_cols_nz) * DIV_DIVISOR_W'(w_dv_nz);
    assign w_step_div_y = DIV_DIVISOR_W'(w_rows_nz) * DIV_DIVISOR_W'(w_dv_nz);

    // scaling products for absolute mode
    assign w_prod_x = DIV_DIVIDEND_W'(r_x) * DIV_DIVIDEND_W'(r_cfg_cols);
    assign w_prod_y = DIV_DIVIDEND_W'(r_y) * DIV_DIVIDEND_W'(r_cfg_rows);

    // coordinate assembly and motion against the previous point
    assign w_x_raw   = {i_in.byte0[COORD_HIGH_W-1:0], i_in.byte1, i_in.byte2};
    assign w_y_raw   = {i_in.byte3[COORD_HIGH_W-1:0], i_in.byte4, i_in.byte5};
    assign w_x_clamp = (w_x_raw > r_cfg_max_x) ? r_cfg_max_x : w_x_raw;
    assign w_y_clamp = (w_y_raw > r_cfg_max_y) ? r_cfg_max_y : w_y_raw;
    assign w_diff_x  = $signed({2'b00, w_x_raw}) - $signed({r_prev_x[16], r_prev_x});
    assign w_diff_y  = $signed({2'b00, w_y_raw}) - $signed({2'b00, r_prev_y});

    // macro code: last set bank bit wins
    always_comb begin
        w_macro = '0;
        if (i_in.byte3[BANK0_BIT]) w_macro = {1'b0, i_in.byte6};
        if (i_in.byte3[BANK1_BIT]) w_macro = {1'b0, i_in.byte6} + MACRO_BANK1_OFFSET;
        if (i_in.byte3[BANK2_BIT]) w_macro = {1'b0, i_in.byte6} + MACRO_BANK2_OFFSET;
    end

    assign w_in_accept = i_in.valid && w_in_ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_q17       = w_div_quo[16:0];
    assign w_jump      = (r_adx > {1'b0, r_thx}) || (r_ady > {1'b0, w_div_quo[15:0]});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) n_state = i_in.byte0[PROX_BIT] ? ST_PREP : ST_FIN;
            ST_PREP: n_state = (r_kind == KIND_ABSOLUTE) ? ST_SX : ST_THX;
            ST_THX:  if (w_div_done) n_state = ST_THY;
            ST_THY:  if (w_div_done) n_state = w_jump ? ST_FIN : ST_QX;
            ST_QX:   if (w_div_done) n_state = ST_QY;
            ST_QY:   if (w_div_done) n_state = ST_DX;
            ST_DX:   if (w_div_done) n_state = ST_DY;
            ST_DY:   if (w_div_done) n_state = ST_FIN;
            ST_SX:   if (w_div_done) n_state = ST_SY;
            ST_SY:   if (w_div_done) n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: launch the division of the state being entered
    always_comb begin
        w_in_ready        = (r_state == ST_IDLE);
        w_fin_load        = (r_state == ST_FIN) && w_out_free;
        w_div_req.start   = 1'b0;
        w_div_req.long_op = 1'b0;
        w_div_dividend    = '0;
        w_div_divisor     = DIV_DIVISOR_W'(1);
        if (n_state != r_state) begin
            unique case (n_state)
                ST_THX: begin
                    w_div_req.start = 1'b1;
                    w_div_dividend  = DIV_DIVIDEND_W'(r_cfg_max_x);
                    w_div_divisor   = DIV_DIVISOR_W'(w_dv_nz);
                end
                ST_THY: begin
                    w_div_req.start = 1'b1;
                    w_div_dividend  = DIV_DIVIDEND_W'(r_cfg_max_y);
                    w_div_divisor   = DIV_DIVISOR_W'(w_dv_nz);
                end
                ST_QX: begin
                    w_div_req.start = 1'b1;
                    w_div_dividend  = DIV_DIVIDEND_W'(r_cfg_max_x);
                    w_div_divisor   = w_step_div_x;
                end
                ST_QY: begin
                    w_div_req.start = 1'b1;
                    w_div_dividend  = DIV_DIVIDEND_W'(r_cfg_max_y);
                    w_div_divisor   = w_step_div_y;
                end
                ST_DX: begin
                    w_div_req.start = 1'b1;
                    w_div_dividend  = DIV_DIVIDEND_W'(r_adx);
                    w_div_divisor   = DIV_DIVISOR_W'(r_qx);
                end
                ST_DY: begin
                    w_div_req.start = 1'b1;
                    w_div_dividend  = DIV_DIVIDEND_W'(r_ady);
                    w_div_divisor   = DIV_DIVISOR_W'(r_qy);
                end
                ST_SX: begin
                    w_div_req.start   = 1'b1;
                    w_div_req.long_op = 1'b1;
                    w_div_dividend    = w_prod_x;
                    w_div_divisor     = DIV_DIVISOR_W'(w_mx_nz);
                end
                ST_SY: begin
                    w_div_req.start   = 1'b1;
                    w_div_req.long_op = 1'b1;
                    w_div_dividend    = w_prod_y;
                    w_div_divisor     = DIV_DIVISOR_W'(w_my_nz);
                end
                default: ;
            endcase
        end
    end

    // shared divider
    tpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // control state, configuration and previous point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_prev_x        <= -17'sd1;
            r_prev_y        <= '0;
            r_cfg_macro_pad <= 1'b0;
            r_cfg_absolute  <= 1'b0;
            r_cfg_max_x     <= RST_MAX_X;
            r_cfg_max_y     <= RST_MAX_Y;
            r_cfg_cols      <= RST_SCREEN_COLS;
            r_cfg_rows      <= RST_SCREEN_ROWS;
            r_cfg_jump_div  <= RST_JUMP_DIVISOR;
        end else begin
            r_state <= n_state;

            if (w_fin_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // previous point follows the report kind
            if (w_fin_load) begin
                if (r_kind == KIND_CLEARED) begin
                    r_prev_x <= -17'sd1;
                end else if (r_kind == KIND_ABSOLUTE || r_kind == KIND_RELATIVE) begin
                    r_prev_x <= $signed({1'b0, r_x});
                    r_prev_y <= r_y;
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IS_MACRO_PAD: r_cfg_macro_pad <= i_cfg_data[0];
                    CFG_ABSOLUTE:     r_cfg_absolute  <= i_cfg_data[0];
                    CFG_MAX_X:        r_cfg_max_x     <= i_cfg_data;
                    CFG_MAX_Y:        r_cfg_max_y     <= i_cfg_data;
                    CFG_SCREEN_COLS:  r_cfg_cols      <= i_cfg_data[9:0];
                    CFG_SCREEN_ROWS:  r_cfg_rows      <= i_cfg_data[9:0];
                    CFG_JUMP_DIVISOR: r_cfg_jump_div  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // packet capture, division results and staged report
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_x   <= r_cfg_absolute ? w_x_clamp : w_x_raw;
            r_y   <= r_cfg_absolute ? w_y_clamp : w_y_raw;
            r_sdx <= w_diff_x[17];
            r_sdy <= w_diff_y[17];
            r_adx <= w_diff_x[17] ? 17'(-w_diff_x) : w_diff_x[16:0];
            r_ady <= w_diff_y[17] ? 17'(-w_diff_y) : w_diff_y[16:0];
            r_sx  <= '0;
            r_sy  <= '0;
            r_dx  <= '0;
            r_dy  <= '0;
            r_btn <= '0;
            r_mac <= '0;
            if (!i_in.byte0[PROX_BIT]) begin
                if (!r_cfg_macro_pad) begin
                    r_kind <= KIND_CLEARED;
                end else if (i_in.byte0[BTN_FLAG_BIT]) begin
                    r_kind <= KIND_MACRO;
                    r_mac  <= w_macro;
                end else begin
                    r_kind <= KIND_NO_CHANGE;
                end
            end else begin
                r_kind <= r_cfg_absolute ? KIND_ABSOLUTE : KIND_RELATIVE;
                r_btn  <= i_in.byte3[BANK2_BIT:BANK0_BIT];
            end
        end

        if (w_div_done) begin
            unique case (r_state)
                ST_THX:  r_thx <= w_div_quo[15:0];
                ST_QX:   r_qx  <= (w_div_quo[15:0] == '0) ? 16'd1 : w_div_quo[15:0];
                ST_QY:   r_qy  <= (w_div_quo[15:0] == '0) ? 16'd1 : w_div_quo[15:0];
                ST_DX:   r_dx  <= r_sdx ? -$signed({1'b0, w_q17}) : $signed({1'b0, w_q17});
                ST_DY:   r_dy  <= r_sdy ? -$signed({1'b0, w_q17}) : $signed({1'b0, w_q17});
                ST_SX:   r_sx  <= w_div_quo[9:0];
                ST_SY:   r_sy  <= w_div_quo[9:0];
                default: ;
            endcase
        end

        if (w_fin_load) begin
            r_o_kind <= r_kind;
            r_o_sx   <= r_sx;
            r_o_sy   <= r_sy;
            r_o_dx   <= r_dx;
            r_o_dy   <= r_dy;
            r_o_btn  <= r_btn;
            r_o_mac  <= r_mac;
        end
    end

    // ports
    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.report_kind = r_o_kind;
    assign o_out.screen_x    = r_o_sx;
    assign o_out.screen_y    = r_o_sy;
    assign o_out.delta_x     = r_o_dx;
    assign o_out.delta_y     = r_o_dy;
    assign o_out.buttons     = r_o_btn;
    assign o_out.macro_code  = r_o_mac;

endmodule

FILE: sv/tpd_div.sv
module tpd_div
    import tpd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_req                  i_req,
    input  logic [DIV_DIVIDEND_W-1:0] i_dividend,
    input  logic [DIV_DIVISOR_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [DIV_DIVIDEND_W-1:0] o_quotient
);

    typedef struct packed {
        logic [DIV_DIVISOR_W-1:0]  rem;
        logic [DIV_DIVIDEND_W-1:0] quo;
    } t_div_acc;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div_acc div_step(t_div_acc acc, logic [DIV_DIVISOR_W-1:0] dvs);
        t_div_acc               res;
        logic [DIV_DIVISOR_W:0] trial;
        trial = {acc.rem, acc.quo[DIV_DIVIDEND_W-1]};
        res.quo = {acc.quo[DIV_DIVIDEND_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
            res.rem    = DIV_DIVISOR_W'(trial - {1'b0, dvs});
            res.quo[0] = 1'b1;
        end else begin
            res.rem = trial[DIV_DIVISOR_W-1:0];
        end
        return res;
    endfunction

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_CNT_W-1:0]     r_cnt;
    t_div_acc                 r_acc;
    logic [DIV_DIVISOR_W-1:0] r_dvs;
    t_div_acc                 w_step1;
    t_div_acc                 w_step2;

    // two dependent steps per cycle
    always_comb begin
        w_step1 = div_step(r_acc, r_dvs);
        w_step2 = div_step(w_step1, r_dvs);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.long_op ? DIV_CNT_W'(DIV_LONG_CYCLES)
                                        : DIV_CNT_W'(DIV_SHORT_CYCLES);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient; short operands are pre-aligned to the top
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc.rem <= '0;
            r_acc.quo <= i_req.long_op ? i_dividend
                       : {i_dividend[DIV_DIVIDEND_W-DIV_SHORT_SHIFT-1:0],
                          {DIV_SHORT_SHIFT{1'b0}}};
            r_dvs     <= i_divisor;
        end else if (r_busy) begin
            r_acc <= w_step2;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc.quo;

endmodule

FILE: sv/tpd_checker.sv
module tpd_checker
    import tpd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         i_out_kind,
    input logic [9:0]         i_out_sx,
    input logic [9:0]         i_out_sy,
    input logic signed [17:0] i_out_dx,
    input logic signed [17:0] i_out_dy,
    input logic [2:0]         i_out_btn,
    input logic [8:0]         i_out_mac
);

    // a stalled report beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("report beat dropped while stalled");

    // a stalled report beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_out_kind, i_out_sx, i_out_sy, i_out_dx, i_out_dy,
                     i_out_btn, i_out_mac}))
        else $error("report payload changed while stalled");

    // one packet at a time: busy right after a packet beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("packet taken while previous packet still in work");

    // fields outside the report kind read as zero
    a_fields_by_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_out_kind == KIND_RELATIVE) || (i_out_dx == '0 && i_out_dy == '0)) &&
            ((i_out_kind == KIND_ABSOLUTE) || (i_out_sx == '0 && i_out_sy == '0)) &&
            ((i_out_kind == KIND_MACRO) || (i_out_mac == '0)) &&
            ((i_out_kind == KIND_ABSOLUTE) || (i_out_kind == KIND_RELATIVE) ||
             (i_out_btn == '0)))
        else $error("report field set for wrong kind");

endmodule

bind tablet_packet_decoder_unit tpd_checker u_tpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.report_kind),
    .i_out_sx    (o_out.screen_x),
    .i_out_sy    (o_out.screen_y),
    .i_out_dx    (o_out.delta_x),
    .i_out_dy    (o_out.delta_y),
    .i_out_btn   (o_out.buttons),
    .i_out_mac   (o_out.macro_code)
);

FILE: bench/tablet_packet_decoder_checker.sv
module tablet_packet_decoder_checker
    import tpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    tpd_in_if                      i_pkt,
    tpd_out_if                     i_rep,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         sx;
        logic [9:0]         sy;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [2:0]         btn;
        logic [8:0]         mac;
    } report_t;

    // shadow copy of the block's registers
    logic        macro_pad;
    logic        abs_mode;
    logic [15:0] lim_x;
    logic [15:0] lim_y;
    logic [9:0]  cells_x;
    logic [9:0]  cells_y;
    logic [7:0]  jump_div;

    // previous pen point, -1 in x means none
    logic signed [17:0] last_x;
    logic signed [17:0] last_y;

    report_t expected_reports[$];
    report_t want_rep;
    int      fail_count   = 0;
    int      report_count = 0;
    int      pending      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic flag_error(input string msg);
        $display("checker: %s", msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic signed [18:0] got,
                                 input logic signed [18:0] want);
        if (got !== want) begin
            flag_error($sformatf("report %0d: %s got %0d want %0d",
                                 report_count, name, got, want));
        end
    endtask

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // decode one packet and advance the previous point
    function automatic report_t decode_packet(input logic [7:0] b0, input logic [6:0] b1,
                                              input logic [6:0] b2, input logic [7:0] b3,
                                              input logic [6:0] b4, input logic [6:0] b5,
                                              input logic [7:0] b6);
        report_t    r;
        logic [8:0] code;
        int         x, y, px, py, lx, ly, mx, my, dv, qx, qy;
        r    = '0;
        code = '0;
        if (!b0[PROX_BIT]) begin
            // out of proximity
            if (macro_pad) begin
                if (b0[BTN_FLAG_BIT]) begin
                    if (b3[BANK0_BIT]) code = {1'b0, b6};
                    if (b3[BANK1_BIT]) code = b6 + MACRO_BANK1_OFFSET;
                    if (b3[BANK2_BIT]) code = b6 + MACRO_BANK2_OFFSET;
                    r.kind = KIND_MACRO;
                    r.mac  = code;
                end else begin
                    r.kind = KIND_NO_CHANGE;
                end
            end else begin
                last_x = -18'sd1;
                r.kind = KIND_CLEARED;
            end
        end else begin
            x  = {b0[1:0], b1, b2};
            y  = {b3[1:0], b4, b5};
            lx = lim_x;
            ly = lim_y;
            mx = (lx == 0) ? 1 : lx;
            my = (ly == 0) ? 1 : ly;
            dv = (jump_div == 0) ? 1 : int'(jump_div);
            if (abs_mode) begin
                // clamp, then scale to cells
                if (x > lx) x = lx;
                if (y > ly) y = ly;
                r.sx   = 10'((x * int'(cells_x)) / mx);
                r.sy   = 10'((y * int'(cells_y)) / my);
                r.kind = KIND_ABSOLUTE;
            end else begin
                px = last_x;
                py = last_y;
                // a large jump restarts the previous point
                if (magnitude(x - px) > lx / dv || magnitude(y - py) > ly / dv) begin
                    px = x;
                    py = y;
                end
                qx = lx / ((cells_x == 0) ? 1 : int'(cells_x)) / dv;
                qy = ly / ((cells_y == 0) ? 1 : int'(cells_y)) / dv;
                if (qx == 0) qx = 1;
                if (qy == 0) qy = 1;
                r.dx   = 18'((x - px) / qx);
                r.dy   = 18'((y - py) / qy);
                r.kind = KIND_RELATIVE;
            end
            last_x = 18'(x);
            last_y = 18'(y);
            r.btn  = b3[BANK2_BIT:BANK0_BIT];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            macro_pad = 1'b0;
            abs_mode  = 1'b0;
            lim_x     = RST_MAX_X;
            lim_y     = RST_MAX_Y;
            cells_x   = RST_SCREEN_COLS;
            cells_y   = RST_SCREEN_ROWS;
            jump_div  = RST_JUMP_DIVISOR;
            last_x    = -18'sd1;
            last_y    = '0;
            expected_reports.delete();
            pending   = 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IS_MACRO_PAD: macro_pad = i_cfg_data[0];
                    CFG_ABSOLUTE:     abs_mode  = i_cfg_data[0];
                    CFG_MAX_X:        lim_x     = i_cfg_data;
                    CFG_MAX_Y:        lim_y     = i_cfg_data;
                    CFG_SCREEN_COLS:  cells_x   = i_cfg_data[9:0];
                    CFG_SCREEN_ROWS:  cells_y   = i_cfg_data[9:0];
                    CFG_JUMP_DIVISOR: jump_div  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // accepted packet beat
            if (i_pkt.valid && i_pkt.ready) begin
                expected_reports.push_back(decode_packet(i_pkt.byte0, i_pkt.byte1,
                    i_pkt.byte2, i_pkt.byte3, i_pkt.byte4, i_pkt.byte5, i_pkt.byte6));
            end
            // accepted report beat
            if (i_rep.valid && i_rep.ready) begin
                report_count++;
                if (expected_reports.size() == 0) begin
                    flag_error($sformatf("report %0d: no packet waiting for it",
                                         report_count));
                end else begin
                    want_rep = expected_reports.pop_front();
                    compare_field("report_kind", i_rep.report_kind, want_rep.kind);
                    compare_field("screen_x", i_rep.screen_x, want_rep.sx);
                    compare_field("screen_y", i_rep.screen_y, want_rep.sy);
                    compare_field("delta_x", i_rep.delta_x, want_rep.dx);
                    compare_field("delta_y", i_rep.delta_y, want_rep.dy);
                    compare_field("buttons", i_rep.buttons, want_rep.btn);
                    compare_field("macro_code", i_rep.macro_code, want_rep.mac);
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

FILE: bench/tablet_packet_decoder_unit_test.sv
module tablet_packet_decoder_unit_test
    import tpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic        macro;
        logic        absm;
        logic [15:0] mx;
        logic [15:0] my;
        logic [9:0]  cols;
        logic [9:0]  rows;
        logic [7:0]  div;
    } tablet_setup_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;

    // stimulus controls shared between processes
    bit calm;
    bit long_hold_go;
    bit sender_idle_on;
    int sender_mode_left;
    int sent_x;
    int sent_y;

    tpd_in_if  in_ch ();
    tpd_out_if out_ch ();

    tablet_packet_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tablet_packet_decoder_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pkt       (in_ch),
        .i_rep       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tablet_packet_decoder_unit_test: FAIL");
            $finish;
        end
    end

    // report side back-pressure
    initial begin : receiver
        int mode_left;
        bit idle_on;
        out_ch.ready = 1'b0;
        mode_left    = 0;
        idle_on      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                idle_on   = ($urandom_range(0, 2) != 0);
                mode_left = 64;
            end
            mode_left--;
            if (long_hold_go) begin
                out_ch.ready <= 1'b0;
                long_hold_go = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // offer one packet beat, return at the falling edge after acceptance
    task automatic send_packet(input logic [7:0] b0, input logic [6:0] b1,
                               input logic [6:0] b2, input logic [7:0] b3,
                               input logic [6:0] b4, input logic [6:0] b5,
                               input logic [7:0] b6);
        if (sender_mode_left == 0) begin
            sender_idle_on   = ($urandom_range(0, 2) != 0);
            sender_mode_left = 20;
        end
        sender_mode_left--;
        if (!calm && sender_idle_on && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.byte0 <= b0;
        in_ch.byte1 <= b1;
        in_ch.byte2 <= b2;
        in_ch.byte3 <= b3;
        in_ch.byte4 <= b4;
        in_ch.byte5 <= b5;
        in_ch.byte6 <= b6;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding report
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // write all seven registers, one per cycle
    task automatic write_setup(input tablet_setup_t s);
        logic [CFG_DATA_W-1:0] vals [7];
        vals[CFG_IS_MACRO_PAD] = CFG_DATA_W'(s.macro);
        vals[CFG_ABSOLUTE]     = CFG_DATA_W'(s.absm);
        vals[CFG_MAX_X]        = s.mx;
        vals[CFG_MAX_Y]        = s.my;
        vals[CFG_SCREEN_COLS]  = CFG_DATA_W'(s.cols);
        vals[CFG_SCREEN_ROWS]  = CFG_DATA_W'(s.rows);
        vals[CFG_JUMP_DIVISOR] = CFG_DATA_W'(s.div);
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= vals[i];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly anywhere from one to the top, with zero, one and the top value now and then
    function automatic logic [15:0] pick_value(input int unsigned top);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'(top);
            default: return 16'($urandom_range(1, top));
        endcase
    endfunction

    function automatic tablet_setup_t random_setup();
        tablet_setup_t s;
        s.macro = 1'($urandom_range(0, 1));
        s.absm  = 1'($urandom_range(0, 1));
        s.mx    = pick_value(65535);
        s.my    = pick_value(65535);
        s.cols  = 10'(pick_value(1023));
        s.rows  = 10'(pick_value(1023));
        s.div   = 8'(pick_value(255));
        return s;
    endfunction

    // out of proximity noise, far points, or pen moves near the last point
    task automatic send_random();
        int unsigned pick;
        int          span;
        int          x, y;
        logic [7:0]  b0, b3;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            b0 = 8'($urandom);
            b0[PROX_BIT] = 1'b0;
            send_packet(b0, 7'($urandom), 7'($urandom), 8'($urandom), 7'($urandom),
                        7'($urandom), 8'($urandom));
        end else begin
            if (pick < 35) begin
                x = $urandom_range(0, 65535);
                y = $urandom_range(0, 65535);
            end else begin
                case ($urandom_range(0, 3))
                    0:       span = 3;
                    1:       span = 40;
                    2:       span = 600;
                    default: span = 9000;
                endcase
                x = sent_x + int'($urandom_range(0, 2 * span)) - span;
                y = sent_y + int'($urandom_range(0, 2 * span)) - span;
                if (x < 0) x = 0;
                if (x > 65535) x = 65535;
                if (y < 0) y = 0;
                if (y > 65535) y = 65535;
            end
            sent_x = x;
            sent_y = y;
            b0 = 8'($urandom);
            b0[PROX_BIT] = 1'b1;
            b0[1:0] = x[15:14];
            b3 = 8'($urandom);
            b3[1:0] = y[15:14];
            send_packet(b0, x[13:7], x[6:0], b3, y[13:7], y[6:0], 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase;
        int k;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.byte0      = '0;
        in_ch.byte1      = '0;
        in_ch.byte2      = '0;
        in_ch.byte3      = '0;
        in_ch.byte4      = '0;
        in_ch.byte5      = '0;
        in_ch.byte6      = '0;
        calm             = 1'b0;
        long_hold_go     = 1'b0;
        sender_idle_on   = 1'b0;
        sender_mode_left = 0;
        sent_x           = 0;
        sent_y           = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: cleared, first point, small and negative motion, extremes
        send_packet(8'h00, 7'h00, 7'h00, 8'h00, 7'h00, 7'h00, 8'h00);
        send_packet(8'h40, 7'h00, 7'h00, 8'h00, 7'h00, 7'h00, 8'h00);
        send_packet(8'h40, 7'h00, 7'h05, 8'h00, 7'h00, 7'h09, 8'h00);
        send_packet(8'h43, 7'h7f, 7'h7f, 8'hff, 7'h7f, 7'h7f, 8'hff);
        send_packet(8'h43, 7'h7f, 7'h70, 8'h03, 7'h7f, 7'h60, 8'h00);
        send_packet(8'hbf, 7'h7f, 7'h7f, 8'hff, 7'h7f, 7'h7f, 8'hff);

        // macro pad: each bank, all banks with the top key, no button flag
        wait_drained();
        write_setup('{1'b1, 1'b0, 16'd5103, 16'd3711, 10'd80, 10'd25, 8'd20});
        send_packet(8'h08, 7'h00, 7'h00, 8'h00, 7'h00, 7'h00, 8'h05);
        send_packet(8'h08, 7'h00, 7'h00, 8'h08, 7'h00, 7'h00, 8'h05);
        send_packet(8'h08, 7'h00, 7'h00, 8'h10, 7'h00, 7'h00, 8'h05);
        send_packet(8'h08, 7'h00, 7'h00, 8'h20, 7'h00, 7'h00, 8'h05);
        send_packet(8'hbf, 7'h7f, 7'h7f, 8'hff, 7'h7f, 7'h7f, 8'hff);
        send_packet(8'hb7, 7'h7f, 7'h7f, 8'hff, 7'h7f, 7'h7f, 8'hff);
        send_packet(8'h48, 7'h01, 7'h02, 8'h08, 7'h03, 7'h04, 8'h00);

        // absolute: zero, clamped maximum, mid point
        wait_drained();
        write_setup('{1'b0, 1'b1, 16'd5103, 16'd3711, 10'd80, 10'd25, 8'd20});
        send_packet(8'h40, 7'h00, 7'h00, 8'h00, 7'h00, 7'h00, 8'h00);
        send_packet(8'h43, 7'h7f, 7'h7f, 8'h3b, 7'h7f, 7'h7f, 8'h00);
        send_packet(8'h40, 7'd19, 7'd119, 8'h10, 7'd14, 7'd63, 8'h00);

        // all registers zero, relative: jump then no motion
        wait_drained();
        write_setup('{1'b0, 1'b0, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0});
        send_packet(8'h40, 7'h00, 7'd10, 8'h00, 7'h00, 7'd10, 8'h00);
        send_packet(8'h40, 7'h00, 7'd10, 8'h00, 7'h00, 7'd10, 8'h00);

        // all registers zero, absolute
        wait_drained();
        write_setup('{1'b0, 1'b1, 16'd0, 16'd0, 10'd0, 10'd0, 8'd0});
        send_packet(8'h43, 7'h7f, 7'h7f, 8'h03, 7'h7f, 7'h7f, 8'h00);

        // motion step rounds to zero and is taken as one
        wait_drained();
        write_setup('{1'b0, 1'b0, 16'd100, 16'd100, 10'd1023, 10'd1023, 8'd1});
        send_packet(8'h40, 7'h00, 7'd50, 8'h00, 7'h00, 7'd50, 8'h00);
        send_packet(8'h40, 7'h00, 7'd120, 8'h00, 7'h00, 7'd20, 8'h00);

        // widest ranges, absolute
        wait_drained();
        write_setup('{1'b0, 1'b1, 16'd65535, 16'd65535, 10'd1023, 10'd1023, 8'd255});
        send_packet(8'h43, 7'h7f, 7'h7f, 8'h03, 7'h7f, 7'h7f, 8'h00);
        send_packet(8'h42, 7'h00, 7'h00, 8'h01, 7'h00, 7'h00, 8'h00);

        // random phases, each under fresh settings
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            write_setup(random_setup());
            if (phase == RANDOM_PHASES - 1) calm = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 2 && k == 10) long_hold_go = 1'b1;
                if (phase == 4 && k == 40) wait_drained();
                send_random();
            end
        end

        // drain and settle
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tablet_packet_decoder_unit_test: PASS");
        end else begin
            $display("tablet_packet_decoder_unit_test: FAIL");
        end
        $finish;
    end

endmodule
